// ===== hw/rtl/bqse_pkg.sv =====
// Package for the boolean query stack evaluator.
// Holds sizes, opcode and status codes, FSM state type and the
// controller/datapath command and status structs. No dependencies.
package bqse_pkg;

  localparam int MAX_INSTRUCTIONS = 24;
  localparam int NUM_PATTERNS     = 16;

  localparam int MATCH_W = 16;
  localparam int PROG_W  = 64;
  localparam int LEN_W   = 5;
  localparam int ADDR_W  = 2;
  localparam int STAT_W  = 2;
  localparam int INSTR_W = 8;

  // Stack holds the initial true entry plus one entry per instruction.
  localparam int STK_W = MAX_INSTRUCTIONS + 1;
  localparam int DEP_W = $clog2(STK_W + 1);
  localparam int PC_W  = $clog2(MAX_INSTRUCTIONS + 1);
  localparam int PAT_W = 4;

  // Configuration register indexes.
  localparam logic [ADDR_W-1:0] REG_PROG0 = 2'd0;
  localparam logic [ADDR_W-1:0] REG_PROG1 = 2'd1;
  localparam logic [ADDR_W-1:0] REG_PROG2 = 2'd2;
  localparam logic [ADDR_W-1:0] REG_LEN   = 2'd3;

  // Opcodes, low nibble of an instruction.
  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_NOT  = 4'd1;
  localparam logic [3:0] OP_POP  = 4'd2;
  localparam logic [3:0] OP_AND  = 4'd3;
  localparam logic [3:0] OP_OR   = 4'd4;
  localparam logic [3:0] OP_XOR  = 4'd5;
  localparam logic [3:0] OP_EQV  = 4'd6;
  localparam logic [3:0] OP_NEQ  = 4'd7;
  localparam logic [3:0] OP_SEL  = 4'd8;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADOP     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;   // load request, reset the stack
    logic step;    // execute the instruction at the program counter
    logic finish;  // reduce the stack into the output register
  } cmd_t;

  typedef struct packed {
    logic done;      // program ended or stopped on an error
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

// ===== hw/rtl/bqse_ctrl.sv =====
// Controller state machine of the boolean query stack evaluator.
// Depends on bqse_pkg; drives commands to bqse_dp from its status.
module bqse_ctrl
  import bqse_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  sts_t   sts,
  output cmd_t   cmd,
  output logic   busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.start = in_valid;
      end
      ST_EXEC: begin
        cmd.step = !sts.done;
      end
      ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bqse_dp.sv =====
// Datapath of the boolean query stack evaluator: program registers,
// one-bit stack, program counter and output register. Depends on bqse_pkg.
module bqse_dp
  import bqse_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_addr,
  input  logic [PROG_W-1:0]   cfg_data,
  input  logic [MATCH_W-1:0]  in_match_bits,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_matched,
  output logic [STAT_W-1:0]   out_status
);

  logic [PROG_W-1:0]  prog0_r, prog1_r, prog2_r;
  logic [LEN_W-1:0]   len_r;
  logic [MATCH_W-1:0] mb_r;
  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic [DEP_W-1:0]   depth_r, depth_nxt;
  logic [STK_W-1:0]   stk_r, stk_nxt;
  logic [STAT_W-1:0]  stat_r, stat_nxt;
  logic               out_valid_r;
  logic               out_matched_r;
  logic [STAT_W-1:0]  out_status_r;

  logic [3*PROG_W-1:0] prog;
  logic [INSTR_W-1:0]  instr;
  logic [3:0]          op;
  logic [PAT_W-1:0]    pat;
  logic [LEN_W-1:0]    len_eff;
  logic [1:0]          need;
  logic [STK_W-1:0]    sh1, sh2, sh3, mask;
  logic                a, b, c, r, wr;
  logic [DEP_W-1:0]    wp;
  logic                matched_fin;
  logic [STAT_W-1:0]   status_fin;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog0_r <= '0;
      prog1_r <= '0;
      prog2_r <= '0;
      len_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PROG0: prog0_r <= cfg_data;
        REG_PROG1: prog1_r <= cfg_data;
        REG_PROG2: prog2_r <= cfg_data;
        REG_LEN:   len_r   <= cfg_data[LEN_W-1:0];
        default:   len_r   <= len_r;
      endcase
    end
  end

  assign len_eff = (len_r > LEN_W'(MAX_INSTRUCTIONS)) ? LEN_W'(MAX_INSTRUCTIONS) : len_r;
  assign prog    = {prog2_r, prog1_r, prog0_r};
  assign instr   = prog[{pc_r, 3'b000} +: INSTR_W];
  assign op      = instr[3:0];
  assign pat     = instr[7:4];

  assign sts.done     = (pc_r >= PC_W'(len_eff)) || (stat_r != STAT_OK);
  assign sts.out_free = !out_valid_r || !out_stall;

  // Top three stack entries; only read when the depth check passes.
  assign sh1 = stk_r >> (depth_r - DEP_W'(1));
  assign sh2 = stk_r >> (depth_r - DEP_W'(2));
  assign sh3 = stk_r >> (depth_r - DEP_W'(3));
  assign c   = sh1[0];
  assign b   = sh2[0];
  assign a   = sh3[0];

  always_comb begin
    case (op)
      OP_PUSH:        need = 2'd0;
      OP_NOT, OP_POP: need = 2'd1;
      OP_SEL:         need = 2'd3;
      default:        need = 2'd2;
    endcase
  end

  always_comb begin
    pc_nxt    = pc_r;
    depth_nxt = depth_r;
    stk_nxt   = stk_r;
    stat_nxt  = stat_r;
    r         = 1'b0;
    wr        = 1'b0;
    wp        = depth_r;
    if (cmd.start) begin
      pc_nxt    = '0;
      depth_nxt = DEP_W'(1);
      stk_nxt   = STK_W'(1);
      stat_nxt  = STAT_OK;
    end else if (cmd.step) begin
      pc_nxt = pc_r + PC_W'(1);
      if (op > OP_SEL) begin
        stat_nxt = STAT_BADOP;
      end else if (depth_r < DEP_W'(need)) begin
        stat_nxt = STAT_UNDERFLOW;
      end else begin
        wr = 1'b1;
        case (op)
          OP_PUSH: begin
            r         = ({1'b0, pat} < (PAT_W+1)'(NUM_PATTERNS)) ? mb_r[pat] : 1'b0;
            wp        = depth_r;
            depth_nxt = depth_r + DEP_W'(1);
          end
          OP_POP: begin
            wr        = 1'b0;
            depth_nxt = depth_r - DEP_W'(1);
          end
          OP_NOT: begin
            r  = !c;
            wp = depth_r - DEP_W'(1);
          end
          OP_SEL: begin
            r         = a ? b : c;
            wp        = depth_r - DEP_W'(3);
            depth_nxt = depth_r - DEP_W'(2);
          end
          default: begin
            case (op)
              OP_AND:  r = b & c;
              OP_OR:   r = b | c;
              OP_XOR:  r = b ^ c;
              OP_EQV:  r = (b == c);
              default: r = (b != c);
            endcase
            wp        = depth_r - DEP_W'(2);
            depth_nxt = depth_r - DEP_W'(1);
          end
        endcase
        if (wr) begin
          stk_nxt = (stk_r & ~(STK_W'(1) << wp)) | (STK_W'(r) << wp);
        end
      end
    end
  end

  // Final reduction: AND of every live entry.
  assign mask = (STK_W'(1) << depth_r) - STK_W'(1);

  always_comb begin
    matched_fin = 1'b0;
    status_fin  = stat_r;
    if (stat_r == STAT_OK) begin
      if (depth_r == '0) begin
        status_fin = STAT_UNDERFLOW;
      end else begin
        matched_fin = ((stk_r & mask) == mask);
      end
    end
  end

  always_ff @(posedge clk) begin
    pc_r    <= pc_nxt;
    depth_r <= depth_nxt;
    stk_r   <= stk_nxt;
    if (!rst_n) begin
      stat_r <= STAT_OK;
    end else begin
      stat_r <= stat_nxt;
    end
    if (cmd.start) begin
      mb_r <= in_match_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.finish) begin
      out_matched_r <= matched_fin;
      out_status_r  <= status_fin;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;
  assign out_status  = out_status_r;

endmodule

// ===== hw/rtl/boolean_query_stack_evaluator.sv =====
// Top level of the boolean query stack evaluator.
// Depends on bqse_pkg, bqse_ctrl and bqse_dp.
//
//   Channel   Ports                                   Direction  Flow control
//   input     in_valid, in_stall, in_match_bits       in         valid/stall
//   result    out_valid, out_stall, out_matched,      out        valid/stall
//             out_status
//   config    cfg_we, cfg_addr, cfg_data              in         write only
//
// A request is loaded, then the instructions execute one at a time (up to 24,
// fewer if an error stops the program), then the state machine sees the end
// of the program and the stack is reduced into the output register. The
// single shared stack makes the instructions run in order, since each
// instruction depends on the stack the last one left.
// Reset (rst_n low, synchronous) clears the program registers, the state
// machine and the output valid. A stall on the result channel only holds the
// finishing step; a new request is taken while a result still waits.
module boolean_query_stack_evaluator
  import bqse_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_addr,
  input  logic [PROG_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MATCH_W-1:0]  in_match_bits,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_matched,
  output logic [STAT_W-1:0]   out_status
);

  cmd_t cmd;
  sts_t sts;
  logic busy;

  // The controller sequences load, execute and finish; the datapath owns
  // every register that holds program, stack or result bits.
  bqse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  bqse_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .in_match_bits (in_match_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_matched   (out_matched),
    .out_status    (out_status)
  );

  // The input side is stalled whenever a request is in flight.
  assign in_stall = busy;

  // An accepted request keeps the input stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after request accepted");

  // A result is loaded only while the output register is free.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result overwrote a waiting result");

  // Error results never report true, and status stays a defined code.
  a_err_false: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (!out_matched &&
      (out_status == STAT_UNDERFLOW || out_status == STAT_BADOP)))
    else $error("error result with bad fields");

endmodule

// ===== tb/boolean_query_stack_evaluator_tb.sv =====
// Self-checking testbench for boolean_query_stack_evaluator: random and directed postfix
// programs and found-bit vectors, with randomly paced requests and result stalls.
// Depends on bqse_pkg and the boolean_query_stack_evaluator RTL.
module boolean_query_stack_evaluator_tb
  import bqse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              matched;
    logic [STAT_W-1:0] status;
  } answer_t;

  typedef logic [INSTR_W-1:0] program_t [MAX_INSTRUCTIONS];

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [ADDR_W-1:0]   cfg_addr = '0;
  logic [PROG_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [MATCH_W-1:0]  in_match_bits = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_matched;
  logic [STAT_W-1:0]   out_status;

  // Our own copy of the program registers, updated as they are written.
  logic [PROG_W-1:0]   prog_words [3] = '{default: '0};
  logic [LEN_W-1:0]    prog_len = '0;

  // Found-bit vectors waiting to be sent, and the answers owed by the block in order.
  logic [MATCH_W-1:0]  pending_queries [$];
  answer_t             awaited_answers [$];

  int                  mismatch_count = 0;
  // While calm is set neither side inserts new gaps or stalls.
  bit                  calm = 1'b0;

  // Driver bookkeeping.
  int                  gap_left = 0;
  int                  issued_count = 0;
  bit                  drain_pause = 1'b0;
  // Monitor bookkeeping.
  int                  stall_left = 0;

  boolean_query_stack_evaluator uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_match_bits (in_match_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_matched   (out_matched),
    .out_status    (out_status)
  );

  always #5ns clk = ~clk;

  // Number of stack entries an opcode consumes.
  function automatic int operands(input logic [3:0] op);
    case (op)
      OP_PUSH:         return 0;
      OP_NOT, OP_POP:  return 1;
      OP_SEL:          return 3;
      default:         return 2;
    endcase
  endfunction

  // Evaluates the currently loaded program against one found-bit vector. The stack
  // starts with a single true entry, every instruction works on the top entries,
  // and whatever is left at the end is ANDed together.
  function automatic answer_t eval_query(input logic [MATCH_W-1:0] found);
    logic [STK_W-1:0]   stk;
    int                 depth;
    int                 steps;
    logic [INSTR_W-1:0] ins;
    logic [3:0]         op;
    logic               r;
    answer_t            ans;
    stk = '0;
    stk[0] = 1'b1;
    depth = 1;
    r = 1'b0;
    ans.matched = 1'b0;
    ans.status = STAT_OK;
    // Lengths beyond the program store are clamped to its size.
    steps = (prog_len > MAX_INSTRUCTIONS) ? MAX_INSTRUCTIONS : int'(prog_len);
    for (int i = 0; i < steps && ans.status == STAT_OK; i++) begin
      ins = prog_words[i / 8][(i % 8) * 8 +: 8];
      op = ins[3:0];
      if (op > OP_SEL) begin
        ans.status = STAT_BADOP;
      end else if (operands(op) > depth) begin
        ans.status = STAT_UNDERFLOW;
      end else begin
        // The pattern index is four bits wide, so it always names a real pattern.
        case (op)
          OP_PUSH: r = found[ins[7:4]];
          OP_NOT:  r = ~stk[depth-1];
          OP_AND:  r = stk[depth-2] & stk[depth-1];
          OP_OR:   r = stk[depth-2] | stk[depth-1];
          OP_XOR:  r = stk[depth-2] ^ stk[depth-1];
          OP_EQV:  r = (stk[depth-2] == stk[depth-1]);
          OP_NEQ:  r = (stk[depth-2] != stk[depth-1]);
          OP_SEL:  r = stk[depth-3] ? stk[depth-2] : stk[depth-1];
          default: r = 1'b0;
        endcase
        depth -= operands(op);
        if (op != OP_POP) begin
          stk[depth] = r;
          depth++;
        end
      end
    end
    if (ans.status == STAT_OK) begin
      // A program that pops the stack empty counts as an underflow.
      if (depth == 0) begin
        ans.status = STAT_UNDERFLOW;
      end else begin
        ans.matched = 1'b1;
        for (int j = 0; j < depth; j++) ans.matched &= stk[j];
      end
    end
    return ans;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Found-bit vectors, biased toward all-set, all-clear and single-bit patterns so
  // that the final AND of the stack comes out true often enough.
  function automatic logic [MATCH_W-1:0] rand_match();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return MATCH_W'(1) << $urandom_range(0, MATCH_W - 1);
      3:       return ~(MATCH_W'(1) << $urandom_range(0, MATCH_W - 1));
      default: return MATCH_W'($urandom);
    endcase
  endfunction

  // Builds a program. Most programs only use instructions the stack depth allows,
  // with an occasional random byte that may underflow or carry an unknown opcode.
  // Noisy programs are random bytes throughout.
  function automatic void gen_program(input bit noisy, output program_t code,
                                      output logic [LEN_W-1:0] len);
    int         depth;
    int         pick;
    logic [3:0] op;
    depth = 1;
    for (int i = 0; i < MAX_INSTRUCTIONS; i++) begin
      if (noisy || $urandom_range(0, 31) == 0) begin
        code[i] = INSTR_W'($urandom);
      end else begin
        op = ($urandom_range(0, 9) < 4) ? OP_PUSH : 4'($urandom_range(0, 8));
        if (operands(op) > depth) op = OP_PUSH;
        code[i] = {4'($urandom), op};
      end
      op = code[i][3:0];
      if (op <= OP_SEL && operands(op) <= depth)
        depth += ((op == OP_POP) ? 0 : 1) - operands(op);
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) len = '0;
    else if (pick < 3) len = LEN_W'($urandom_range(MAX_INSTRUCTIONS + 1, 31));
    else len = LEN_W'($urandom_range(1, MAX_INSTRUCTIONS));
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 10) $display("%0t ns: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Appends one found-bit vector to the requests waiting to be sent.
  task automatic enqueue_query(input logic [MATCH_W-1:0] q);
    pending_queries = {pending_queries, q};
  endtask

  // One register write per clock; the shadow copy follows along.
  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [PROG_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_PROG0: prog_words[0] = val;
      REG_PROG1: prog_words[1] = val;
      REG_PROG2: prog_words[2] = val;
      REG_LEN:   prog_len = val[LEN_W-1:0];
      default:   ;
    endcase
  endtask

  // Packs the instruction bytes, lowest byte first, and writes all four registers.
  task automatic load_program(input program_t code, input logic [LEN_W-1:0] len);
    logic [PROG_W-1:0] word;
    write_reg(REG_LEN, PROG_W'(len));
    for (int w = 0; w < 3; w++) begin
      for (int b = 0; b < 8; b++) word[b*8 +: 8] = code[w*8 + b];
      write_reg(ADDR_W'(w), word);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits at the falling edge, where every assignment has settled, until all queued
  // requests are taken and answered, then lets the block run out its latency.
  task automatic settle();
    while (pending_queries.size() != 0 || in_valid || awaited_answers.size() != 0)
      @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Driver: holds a stalled request, then waits out its gap before offering the next.
  // Every 64th request the driver also waits until every owed answer has arrived,
  // so the block drains completely in the middle of a phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall)
        awaited_answers = {awaited_answers, eval_query(in_match_bits)};
      if (in_valid && in_stall) begin
        // Request still pending; valid and payload stay as they are.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (drain_pause && awaited_answers.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_queries.size() != 0) begin
        in_match_bits <= pending_queries.pop_front();
        in_valid <= 1'b1;
        gap_left = pick_gap();
        drain_pause = (issued_count % 64 == 63);
        issued_count++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result against the oldest owed answer and drives
  // the result stall in random runs of stalled and free cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_answers.size() == 0) begin
          flag_mismatch($sformatf("result with nothing owed: matched=%b status=%0d",
                                  out_matched, out_status));
        end else begin
          answer_t want;
          want = awaited_answers.pop_front();
          if (out_matched !== want.matched)
            flag_mismatch($sformatf("matched: expected %b, got %b",
                                    want.matched, out_matched));
          if (out_status !== want.status)
            flag_mismatch($sformatf("status: expected %0d, got %0d",
                                    want.status, out_status));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        stall_left = pick_gap();
      end else begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end
    end
  end

  // Stimulus: directed programs for every opcode and each corner case, then random
  // programs, each phase loaded while the block is idle.
  initial begin
    program_t          code;
    logic [LEN_W-1:0]  len;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset program has length zero, so the lone true entry is the answer.
    enqueue_query(16'h0000);
    enqueue_query(16'hFFFF);
    settle();

    // Every opcode, pattern indexes at both ends, full program length.
    code = '{8'h00, 8'h10, 8'h03, 8'h20, 8'h04, 8'h30, 8'h05, 8'h40,
             8'h06, 8'h50, 8'h07, 8'h01, 8'h60, 8'h70, 8'h08, 8'h80,
             8'h02, 8'hF0, 8'hE0, 8'h90, 8'h08, 8'hA0, 8'hB0, 8'hC0};
    load_program(code, LEN_W'(MAX_INSTRUCTIONS));
    enqueue_query(16'h0000);
    enqueue_query(16'hFFFF);
    enqueue_query(16'h5555);
    enqueue_query(16'hAAAA);
    enqueue_query(16'h0001);
    enqueue_query(16'h8000);
    settle();

    // Same program with the largest length field, which is clamped.
    load_program(code, '1);
    enqueue_query(16'h1234);
    enqueue_query(16'hFFFF);
    settle();

    // Underflow in the middle: the second AND finds only one entry.
    code = '{default: 8'h00};
    code[0] = {4'd3, OP_PUSH};
    code[1] = {4'd0, OP_AND};
    code[2] = {4'd0, OP_AND};
    load_program(code, LEN_W'(3));
    enqueue_query(16'h0008);
    enqueue_query(16'h0000);
    settle();

    // Popping the only entry leaves the stack empty at the end.
    code = '{default: 8'h00};
    code[0] = {4'd0, OP_POP};
    load_program(code, LEN_W'(1));
    enqueue_query(16'hFFFF);
    settle();

    // Unknown opcode at the first instruction, with all program bits set.
    code = '{default: 8'hFF};
    load_program(code, LEN_W'(MAX_INSTRUCTIONS));
    enqueue_query(16'h0F0F);
    settle();

    // Unknown opcode after a couple of pushes.
    code = '{default: 8'h00};
    code[0] = {4'd0, OP_PUSH};
    code[1] = {4'd1, OP_PUSH};
    code[2] = 8'h49;
    load_program(code, LEN_W'(3));
    enqueue_query(16'h0003);
    settle();

    // Select on all four ways its condition and operands can fall.
    code = '{default: 8'h00};
    code[0] = {4'd0, OP_PUSH};
    code[1] = {4'd1, OP_PUSH};
    code[2] = {4'd2, OP_PUSH};
    code[3] = {4'd0, OP_SEL};
    load_program(code, LEN_W'(4));
    enqueue_query(16'h0003);
    enqueue_query(16'h0005);
    enqueue_query(16'h0004);
    enqueue_query(16'h0002);
    settle();

    // All-zero program words: the deepest stack, every entry pattern zero's bit.
    code = '{default: 8'h00};
    load_program(code, LEN_W'(MAX_INSTRUCTIONS));
    enqueue_query(16'h0001);
    enqueue_query(16'hFFFE);
    settle();

    // Random part: mostly well-formed programs, every fourth one pure noise.
    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph == 2 || ph == 7);
      gen_program(ph % 4 == 3, code, len);
      load_program(code, len);
      for (int k = 0; k < 34; k++) enqueue_query(rand_match());
      settle();
    end

    if (mismatch_count == 0 && awaited_answers.size() == 0) begin
      $display("boolean_query_stack_evaluator regression: pass");
    end else begin
      $display("boolean_query_stack_evaluator regression: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000ns;
    $display("boolean_query_stack_evaluator regression: fail");
    $finish;
  end

endmodule

// ===== boolean_query_stack_evaluator.f =====
hw/rtl/bqse_pkg.sv
hw/rtl/bqse_ctrl.sv
hw/rtl/bqse_dp.sv
hw/rtl/boolean_query_stack_evaluator.sv
tb/boolean_query_stack_evaluator_tb.sv
